>>> src/chs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the convex hull block.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_FEW = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  // datapath micro-operations issued by the controller
  typedef enum logic [5:0] {
    OP_NOP,
    OP_LOAD,
    OP_START,
    OP_ANC_UPD,
    OP_I_CLR,
    OP_DD_LAT,
    OP_LAT_Q,
    OP_MUL_CROSS_ANC,
    OP_MUL_DP,
    OP_MUL_DQ,
    OP_WR_ANG_K,
    OP_K_INC,
    OP_APPEND,
    OP_I_INC,
    OP_SORT_INIT,
    OP_SO_RD,
    OP_LAT_P_ANG,
    OP_RD_ANG_JM1,
    OP_SHIFT,
    OP_WR_ANG_J_P,
    OP_SC_INIT,
    OP_SC_INIT2,
    OP_MUL_CROSS_STK,
    OP_POP,
    OP_LAT_S2,
    OP_PUSH,
    OP_EM_INIT,
    OP_EM_LAT,
    OP_ERR1,
    OP_ERR2,
    OP_E_INC,
    OP_FINISH
  } op_t;

  typedef struct packed {
    logic ovf;
    logic i_last;
    logic i_mlast;
    logic same_anc;
    logic m_zero;
    logic m_lt2;
    logic k_last;
    logic j_zero;
    logic d_gt2;
    logic cr_zero;
    logic cr_neg;
    logic cr_pos;
    logic far;
    logic out_last;
  } dp_status_t;

endpackage

>>> src/chs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_in_if / chs_out_if
// Valid/ready channels for input points and hull results.
// ----------------------------------------------------------------------------
interface chs_in_if #(
  parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface chs_out_if #(
  parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] hull_x;
  logic [COORD_BITS-1:0] hull_y;
  logic                  last_vertex;
  chs_pkg::status_t      status;

  modport source (output valid, hull_x, hull_y, last_vertex, status, input ready);
  modport sink (input valid, hull_x, hull_y, last_vertex, status, output ready);
endinterface

>>> src/convex_hull_angle_sort_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_angle_sort_scan
// Graham scan convex hull over a set of signed integer points.
// ----------------------------------------------------------------------------
// Points enter on in_ch, one per transaction, while the block is loading.
// The transaction with last_point set closes the set; in_ch.ready then
// stays low until the final result of that set has been taken.
// Results leave on out_ch: the hull vertices counterclockwise from the
// anchor (lowest, then leftmost point), last_vertex on the final one, or a
// single result with status 1 (fewer than two directions) or 2 (too many
// points) and zero coordinates.
// Loading accepts one point per cycle while in_valid is high. After the
// last point the sequencer runs the anchor search, the merge of
// same-direction points (keeping the farther one), the insertion sort by
// angle, the scan with its pushes and pops, and the emission of each vertex.
// These phases share one point RAM, one angle RAM and one multiplier pair.
// A stalled receiver simply holds the result register; nothing is lost.
// Synchronous reset returns the block to loading an empty set.
// ----------------------------------------------------------------------------
module convex_hull_angle_sort_scan #(
  parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  chs_in_if.sink     in_ch,
  chs_out_if.source  out_ch
);

  chs_pkg::op_t        op;
  chs_pkg::dp_status_t st;

  chs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_point),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .op        (op)
  );

  chs_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .in_x        (in_ch.point_x),
    .in_y        (in_ch.point_y),
    .st          (st),
    .hull_x      (out_ch.hull_x),
    .hull_y      (out_ch.hull_y),
    .last_vertex (out_ch.last_vertex),
    .status      (out_ch.status)
  );

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  // the final result of a set reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_vertex) |=> in_ch.ready)
    else $error("input not reopened after final result");

  // an error result is always the only one of its set
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != chs_pkg::ST_OK) |-> out_ch.last_vertex)
    else $error("error result without last_vertex");

  // the last point of a set closes the input
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_point) |=> !in_ch.ready)
    else $error("input still open after last point");

endmodule

>>> src/chs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/chs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_dp
// Hull datapath: point, angle and stack memories, counters, cross products.
// ----------------------------------------------------------------------------
module chs_dp #(
  parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  chs_pkg::op_t           op,
  input  logic [COORD_BITS-1:0]  in_x,
  input  logic [COORD_BITS-1:0]  in_y,
  output chs_pkg::dp_status_t    st,
  output logic [COORD_BITS-1:0]  hull_x,
  output logic [COORD_BITS-1:0]  hull_y,
  output logic                   last_vertex,
  output chs_pkg::status_t       status
);

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW + 2;

  logic [CW-1:0] cnt_r, i_r, k_r, m_r, j_r, d_r, e_r;
  logic          ovf_r;
  logic [2*CB-1:0] anc_r, p_r, q_r, s1_r, s2_r;
  logic signed [PW-1:0] prod_a_r, prod_b_r, dp_r;
  logic [CB-1:0] hx_r, hy_r;
  logic          hl_r;
  chs_pkg::status_t hs_r;

  logic          pt_we, ang_we, stk_we;
  logic [AW-1:0] pt_wa, pt_ra, ang_wa, ang_ra, stk_wa, stk_ra;
  logic [2*CB-1:0] pt_wd, ang_wd, stk_wd, pt_rd, ang_rd, stk_rd;
  logic [CW-1:0] jm1, dm3;

  logic [2*CB-1:0] o_v, u_v, v_v;
  logic signed [DW-1:0] ux, uy, vx, vy, ma1, mb1, ma2, mb2;
  logic signed [2*DW-1:0] prod1, prod2;
  logic signed [PW-1:0] cross_w, sum_w;
  logic lower;

  function automatic logic signed [DW-1:0] diff(logic [CB-1:0] a, logic [CB-1:0] b);
    diff = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
  endfunction

  chs_ram #(.WIDTH(2*CB), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(pt_wa), .wdata(pt_wd), .raddr(pt_ra), .rdata(pt_rd)
  );
  chs_ram #(.WIDTH(2*CB), .DEPTH(MAX_POINTS)) u_ang_ram (
    .clk(clk), .we(ang_we), .waddr(ang_wa), .wdata(ang_wd), .raddr(ang_ra), .rdata(ang_rd)
  );
  chs_ram #(.WIDTH(2*CB), .DEPTH(MAX_POINTS)) u_stk_ram (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
  );

  assign jm1 = j_r - CW'(1);
  assign dm3 = d_r - CW'(3);

  // memory ports
  always_comb begin
    pt_we  = 1'b0;
    pt_wa  = cnt_r[AW-1:0];
    pt_wd  = {in_y, in_x};
    pt_ra  = i_r[AW-1:0];
    ang_we = 1'b0;
    ang_wa = k_r[AW-1:0];
    ang_wd = p_r;
    ang_ra = k_r[AW-1:0];
    stk_we = 1'b0;
    stk_wa = d_r[AW-1:0];
    stk_wd = p_r;
    stk_ra = e_r[AW-1:0];
    case (op)
      chs_pkg::OP_LOAD:       pt_we = (cnt_r < CW'(MAX_POINTS));
      chs_pkg::OP_WR_ANG_K:   ang_we = 1'b1;
      chs_pkg::OP_APPEND: begin
        ang_we = 1'b1;
        ang_wa = m_r[AW-1:0];
      end
      chs_pkg::OP_SO_RD:      ang_ra = i_r[AW-1:0];
      chs_pkg::OP_RD_ANG_JM1: ang_ra = jm1[AW-1:0];
      chs_pkg::OP_SHIFT: begin
        ang_we = 1'b1;
        ang_wa = j_r[AW-1:0];
        ang_wd = q_r;
      end
      chs_pkg::OP_WR_ANG_J_P: begin
        ang_we = 1'b1;
        ang_wa = j_r[AW-1:0];
      end
      chs_pkg::OP_SC_INIT: begin
        ang_ra = '0;
        stk_we = 1'b1;
        stk_wa = '0;
        stk_wd = anc_r;
      end
      chs_pkg::OP_SC_INIT2: begin
        stk_we = 1'b1;
        stk_wa = AW'(1);
        stk_wd = ang_rd;
      end
      chs_pkg::OP_POP:        stk_ra = dm3[AW-1:0];
      chs_pkg::OP_PUSH:       stk_we = 1'b1;
      default: ;
    endcase
  end

  // shared multiplier pair: cross product or squared distance terms
  always_comb begin
    o_v = anc_r;
    u_v = p_r;
    v_v = q_r;
    case (op)
      chs_pkg::OP_MUL_CROSS_STK: begin
        o_v = s2_r;
        u_v = s1_r;
        v_v = p_r;
      end
      chs_pkg::OP_MUL_DQ: u_v = q_r;
      default: ;
    endcase
    ux = diff(u_v[CB-1:0], o_v[CB-1:0]);
    uy = diff(u_v[2*CB-1:CB], o_v[2*CB-1:CB]);
    vx = diff(v_v[CB-1:0], o_v[CB-1:0]);
    vy = diff(v_v[2*CB-1:CB], o_v[2*CB-1:CB]);
    if (op == chs_pkg::OP_MUL_DP || op == chs_pkg::OP_MUL_DQ) begin
      ma1 = ux;
      mb1 = ux;
      ma2 = uy;
      mb2 = uy;
    end else begin
      ma1 = ux;
      mb1 = vy;
      ma2 = uy;
      mb2 = vx;
    end
  end

  assign prod1   = ma1 * mb1;
  assign prod2   = ma2 * mb2;
  assign cross_w = prod_a_r - prod_b_r;
  assign sum_w   = prod_a_r + prod_b_r;

  assign lower = ($signed(pt_rd[2*CB-1:CB]) < $signed(anc_r[2*CB-1:CB])) ||
                 ((pt_rd[2*CB-1:CB] == anc_r[2*CB-1:CB]) &&
                  ($signed(pt_rd[CB-1:0]) < $signed(anc_r[CB-1:0])));

  always_ff @(posedge clk) begin
    prod_a_r <= {{2{prod1[2*DW-1]}}, prod1};
    prod_b_r <= {{2{prod2[2*DW-1]}}, prod2};
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      i_r   <= '0;
      k_r   <= '0;
      m_r   <= '0;
      j_r   <= '0;
      d_r   <= '0;
      e_r   <= '0;
    end else begin
      case (op)
        chs_pkg::OP_LOAD: begin
          if (cnt_r < CW'(MAX_POINTS)) begin
            cnt_r <= cnt_r + CW'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end
        chs_pkg::OP_START: begin
          i_r <= '0;
          m_r <= '0;
        end
        chs_pkg::OP_ANC_UPD: begin
          if (i_r == '0 || lower) begin
            anc_r <= pt_rd;
          end
          i_r <= i_r + CW'(1);
        end
        chs_pkg::OP_I_CLR:     i_r <= '0;
        chs_pkg::OP_DD_LAT: begin
          p_r <= pt_rd;
          k_r <= '0;
        end
        chs_pkg::OP_LAT_Q:     q_r <= ang_rd;
        chs_pkg::OP_MUL_DQ:    dp_r <= sum_w;
        chs_pkg::OP_K_INC:     k_r <= k_r + CW'(1);
        chs_pkg::OP_APPEND:    m_r <= m_r + CW'(1);
        chs_pkg::OP_I_INC:     i_r <= i_r + CW'(1);
        chs_pkg::OP_SORT_INIT: i_r <= CW'(1);
        chs_pkg::OP_SO_RD:     j_r <= i_r;
        chs_pkg::OP_LAT_P_ANG: p_r <= ang_rd;
        chs_pkg::OP_SHIFT:     j_r <= jm1;
        chs_pkg::OP_SC_INIT: begin
          s2_r <= anc_r;
          k_r  <= CW'(1);
        end
        chs_pkg::OP_SC_INIT2: begin
          s1_r <= ang_rd;
          d_r  <= CW'(2);
        end
        chs_pkg::OP_POP: begin
          s1_r <= s2_r;
          d_r  <= d_r - CW'(1);
        end
        chs_pkg::OP_LAT_S2:    s2_r <= stk_rd;
        chs_pkg::OP_PUSH: begin
          s2_r <= s1_r;
          s1_r <= p_r;
          d_r  <= d_r + CW'(1);
          k_r  <= k_r + CW'(1);
        end
        chs_pkg::OP_EM_INIT:   e_r <= '0;
        chs_pkg::OP_EM_LAT: begin
          hx_r <= stk_rd[CB-1:0];
          hy_r <= stk_rd[2*CB-1:CB];
          hl_r <= (e_r == d_r - CW'(1));
          hs_r <= chs_pkg::ST_OK;
        end
        chs_pkg::OP_ERR1: begin
          hx_r <= '0;
          hy_r <= '0;
          hl_r <= 1'b1;
          hs_r <= chs_pkg::ST_FEW;
        end
        chs_pkg::OP_ERR2: begin
          hx_r <= '0;
          hy_r <= '0;
          hl_r <= 1'b1;
          hs_r <= chs_pkg::ST_OVF;
        end
        chs_pkg::OP_E_INC:     e_r <= e_r + CW'(1);
        chs_pkg::OP_FINISH: begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st.ovf      = ovf_r;
    st.i_last   = (i_r == cnt_r - CW'(1));
    st.i_mlast  = (i_r == m_r - CW'(1));
    st.same_anc = (pt_rd == anc_r);
    st.m_zero   = (m_r == '0);
    st.m_lt2    = (m_r < CW'(2));
    st.k_last   = (k_r == m_r - CW'(1));
    st.j_zero   = (j_r == '0);
    st.d_gt2    = (d_r > CW'(2));
    st.cr_zero  = (cross_w == '0);
    st.cr_neg   = cross_w[PW-1];
    st.cr_pos   = !cross_w[PW-1] && (cross_w != '0);
    st.far      = (dp_r > sum_w);
    st.out_last = hl_r;
  end

  assign hull_x      = hx_r;
  assign hull_y      = hy_r;
  assign last_vertex = hl_r;
  assign status      = hs_r;

endmodule

>>> src/chs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_ctrl
// Sequencer for load, anchor search, direction merge, sort, scan and emit.
// ----------------------------------------------------------------------------
module chs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  chs_pkg::dp_status_t st,
  output chs_pkg::op_t        op
);

  typedef enum logic [5:0] {
    S_LOAD, S_START, S_ERR2, S_ERR1, S_ANC_RD, S_ANC_UPD,
    S_DD_START, S_DD_RD, S_DD_LAT, S_DD_QRD, S_DD_QLAT, S_DD_MUL, S_DD_TST,
    S_DD_DP, S_DD_DQ, S_DD_FAR, S_DD_KNEXT, S_DD_APPEND, S_DD_NEXT,
    S_SORT_CHK, S_SO_RD, S_SO_KEY, S_SO_JCHK, S_SO_QLAT, S_SO_MUL, S_SO_TST,
    S_SO_INEXT, S_SC_INIT, S_SC_INIT2, S_SC_RD, S_SC_LAT, S_SC_CHK, S_SC_TST,
    S_SC_POPW_A, S_SC_POPW_Z, S_SC_PUSH, S_EM_INIT, S_EM_RD, S_EM_LAT, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    op        = chs_pkg::OP_NOP;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          op = chs_pkg::OP_LOAD;
          if (in_last) state_nxt = S_START;
        end
      end
      S_START: begin
        op        = chs_pkg::OP_START;
        state_nxt = st.ovf ? S_ERR2 : S_ANC_RD;
      end
      S_ERR2: begin
        op        = chs_pkg::OP_ERR2;
        state_nxt = S_OUT;
      end
      S_ERR1: begin
        op        = chs_pkg::OP_ERR1;
        state_nxt = S_OUT;
      end
      S_ANC_RD:   state_nxt = S_ANC_UPD;
      S_ANC_UPD: begin
        op        = chs_pkg::OP_ANC_UPD;
        state_nxt = st.i_last ? S_DD_START : S_ANC_RD;
      end
      S_DD_START: begin
        op        = chs_pkg::OP_I_CLR;
        state_nxt = S_DD_RD;
      end
      S_DD_RD:    state_nxt = S_DD_LAT;
      S_DD_LAT: begin
        op = chs_pkg::OP_DD_LAT;
        if (st.same_anc)    state_nxt = S_DD_NEXT;
        else if (st.m_zero) state_nxt = S_DD_APPEND;
        else                state_nxt = S_DD_QRD;
      end
      S_DD_QRD:   state_nxt = S_DD_QLAT;
      S_DD_QLAT: begin
        op        = chs_pkg::OP_LAT_Q;
        state_nxt = S_DD_MUL;
      end
      S_DD_MUL: begin
        op        = chs_pkg::OP_MUL_CROSS_ANC;
        state_nxt = S_DD_TST;
      end
      S_DD_TST:   state_nxt = st.cr_zero ? S_DD_DP : S_DD_KNEXT;
      S_DD_DP: begin
        op        = chs_pkg::OP_MUL_DP;
        state_nxt = S_DD_DQ;
      end
      S_DD_DQ: begin
        op        = chs_pkg::OP_MUL_DQ;
        state_nxt = S_DD_FAR;
      end
      S_DD_FAR: begin
        // same direction: keep the farther point
        if (st.far) op = chs_pkg::OP_WR_ANG_K;
        state_nxt = S_DD_NEXT;
      end
      S_DD_KNEXT: begin
        op        = chs_pkg::OP_K_INC;
        state_nxt = st.k_last ? S_DD_APPEND : S_DD_QRD;
      end
      S_DD_APPEND: begin
        op        = chs_pkg::OP_APPEND;
        state_nxt = S_DD_NEXT;
      end
      S_DD_NEXT: begin
        op        = chs_pkg::OP_I_INC;
        state_nxt = st.i_last ? S_SORT_CHK : S_DD_RD;
      end
      S_SORT_CHK: begin
        op        = chs_pkg::OP_SORT_INIT;
        state_nxt = st.m_lt2 ? S_ERR1 : S_SO_RD;
      end
      S_SO_RD: begin
        op        = chs_pkg::OP_SO_RD;
        state_nxt = S_SO_KEY;
      end
      S_SO_KEY: begin
        op        = chs_pkg::OP_LAT_P_ANG;
        state_nxt = S_SO_JCHK;
      end
      S_SO_JCHK: begin
        if (st.j_zero) begin
          op        = chs_pkg::OP_WR_ANG_J_P;
          state_nxt = S_SO_INEXT;
        end else begin
          op        = chs_pkg::OP_RD_ANG_JM1;
          state_nxt = S_SO_QLAT;
        end
      end
      S_SO_QLAT: begin
        op        = chs_pkg::OP_LAT_Q;
        state_nxt = S_SO_MUL;
      end
      S_SO_MUL: begin
        op        = chs_pkg::OP_MUL_CROSS_ANC;
        state_nxt = S_SO_TST;
      end
      S_SO_TST: begin
        if (st.cr_pos) begin
          op        = chs_pkg::OP_SHIFT;
          state_nxt = S_SO_JCHK;
        end else begin
          op        = chs_pkg::OP_WR_ANG_J_P;
          state_nxt = S_SO_INEXT;
        end
      end
      S_SO_INEXT: begin
        op        = chs_pkg::OP_I_INC;
        state_nxt = st.i_mlast ? S_SC_INIT : S_SO_RD;
      end
      S_SC_INIT: begin
        op        = chs_pkg::OP_SC_INIT;
        state_nxt = S_SC_INIT2;
      end
      S_SC_INIT2: begin
        op        = chs_pkg::OP_SC_INIT2;
        state_nxt = S_SC_RD;
      end
      S_SC_RD:    state_nxt = S_SC_LAT;
      S_SC_LAT: begin
        op        = chs_pkg::OP_LAT_P_ANG;
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (st.d_gt2) begin
          op        = chs_pkg::OP_MUL_CROSS_STK;
          state_nxt = S_SC_TST;
        end else begin
          state_nxt = S_SC_PUSH;
        end
      end
      S_SC_TST: begin
        // right turn pops and rechecks, collinear pops once
        if (st.cr_neg) begin
          op        = chs_pkg::OP_POP;
          state_nxt = S_SC_POPW_A;
        end else if (st.cr_zero) begin
          op        = chs_pkg::OP_POP;
          state_nxt = S_SC_POPW_Z;
        end else begin
          state_nxt = S_SC_PUSH;
        end
      end
      S_SC_POPW_A: begin
        op        = chs_pkg::OP_LAT_S2;
        state_nxt = S_SC_CHK;
      end
      S_SC_POPW_Z: begin
        op        = chs_pkg::OP_LAT_S2;
        state_nxt = S_SC_PUSH;
      end
      S_SC_PUSH: begin
        op        = chs_pkg::OP_PUSH;
        state_nxt = st.k_last ? S_EM_INIT : S_SC_RD;
      end
      S_EM_INIT: begin
        op        = chs_pkg::OP_EM_INIT;
        state_nxt = S_EM_RD;
      end
      S_EM_RD:    state_nxt = S_EM_LAT;
      S_EM_LAT: begin
        op        = chs_pkg::OP_EM_LAT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (st.out_last) begin
            op        = chs_pkg::OP_FINISH;
            state_nxt = S_LOAD;
          end else begin
            op        = chs_pkg::OP_E_INC;
            state_nxt = S_EM_RD;
          end
        end
      end
      default:    state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
